// ----- design/skf_pkg.sv -----
package skf_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_CFG = 6;

    localparam logic [2:0] CFG_PROC_NOISE = 3'd0;
    localparam logic [2:0] CFG_NOISE_A    = 3'd1;
    localparam logic [2:0] CFG_NOISE_B    = 3'd2;
    localparam logic [2:0] CFG_SINGLE     = 3'd3;
    localparam logic [2:0] CFG_INIT_EST   = 3'd4;
    localparam logic [2:0] CFG_INIT_VAR   = 3'd5;

    localparam logic [30:0] RST_PROC_NOISE = 31'd655;
    localparam logic [30:0] RST_NOISE      = 31'd65536;
    localparam logic [30:0] RST_INIT_VAR   = 31'd65536;

    // multiplier request from sequencer to shared unit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;
endpackage

// ----- design/skf_mul.sv -----
// Shared multiplier: 64x64 -> low 64 bits, summed from 32x32 partial products.
// Only the low 64 bits are kept, so two's complement and unsigned operands agree.
module skf_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [63:0]       o_prod
);
    logic [1:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic [63:0] r_a, r_b, r_acc, n_acc;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    always_comb begin
        case (r_step)
            2'd0: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            2'd2: begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            default: begin w_x = 32'd0; w_y = 32'd0; end
        endcase
        w_pp = 64'(w_x) * 64'(w_y);
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = 2'd0;
            n_acc  = 64'd0;
        end else if (r_busy) begin
            case (r_step)
                2'd0: n_acc = r_acc + w_pp;
                2'd1, 2'd2: n_acc = r_acc + {w_pp[31:0], 32'd0};
                default: n_acc = r_acc;
            endcase
            n_step = r_step + 2'd1;
            if (r_step == 2'd2) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_acc <= n_acc;
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
    end

    assign o_done = r_busy && (r_step == 2'd2);
    assign o_prod = r_acc + {w_pp[31:0], 32'd0};
endmodule

// ----- design/skf_div.sv -----
// Restoring fractional divider: floor(num * 2^FRAC / den), one bit per cycle.
// num <= den is guaranteed by the caller, so the integer quotient is 0 or 1.
module skf_div #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_num,
    input  logic [63:0]          i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quot
);
    localparam int CW = $clog2(FRAC_BITS + 1);
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [64:0]        r_rem;
    logic [63:0]        r_den;
    logic [FRAC_BITS:0] r_q;
    logic [64:0]        w_sh;
    logic               w_ge;

    assign w_sh = {r_rem[63:0], 1'b0};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(FRAC_BITS - 1)) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_den <= i_den;
            // integer step
            if (i_num >= i_den) begin
                r_rem <= {1'b0, i_num - i_den};
                r_q   <= (FRAC_BITS+1)'(1);
            end else begin
                r_rem <= {1'b0, i_num};
                r_q   <= '0;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_q   <= {r_q[FRAC_BITS-1:0], w_ge};
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(FRAC_BITS - 1));
    assign o_quot = {r_q[FRAC_BITS-1:0], w_ge};
endmodule

// ----- design/scalar_kalman_dual_measurement.sv -----
// Scalar random-walk Kalman filter fusing one or two Q16.16 readings per
// transfer. One transfer in gives one result out. An update runs on a
// sequencer that drives one shared multiplier and one bit-serial gain
// divider. A dual update runs seven multiplies and two divides in series,
// a single-mode update one divide and two multiplies. A zero determinant
// is flagged as a fault and ends a dual update after its two determinant
// multiplies, a single-mode one before any operation. The next item is accepted as
// early as the cycle its predecessor's result turns valid. The result sits in
// an output register; a stalled receiver only holds the sequencer in its last
// step once the following update is done. The input is not ready while an
// update runs or while a configuration write is offered; configuration is
// taken only between updates. Writing init_estimate or init_variance also
// loads the filter state.
module scalar_kalman_dual_measurement #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_meas_a,
    input  logic [31:0] i_meas_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_estimate,
    output logic [30:0] o_variance,
    output logic        o_div_fault,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_DET1 = 4'd1, S_DET2 = 4'd2,
        S_NUMA = 4'd3, S_NUMB = 4'd4, S_DIVA = 4'd5, S_DIVB = 4'd6,
        S_CORA = 4'd7, S_CORB = 4'd8, S_VAR = 4'd9, S_FIN = 4'd10,
        S_OUT = 4'd11;

    logic [30:0] r_q, r_ra, r_rb, r_var;
    logic        r_single;
    logic [31:0] r_est;
    logic [3:0]  r_st;
    logic [31:0] r_za, r_zb;
    logic [30:0] r_p;
    logic [63:0] r_d, r_na, r_nb, r_delta;
    logic [FRAC_BITS:0] r_ka, r_kb;
    logic        r_wait, r_fault;
    logic [31:0] r_oest;
    logic [30:0] r_ovar;
    logic        r_ofault;

    logic        w_cfg_fire, w_in_fire, w_out_load;
    skf_pkg::t_mul_req w_mreq;
    logic        w_mdone, w_ddone;
    logic [63:0] w_prod;
    logic [FRAC_BITS:0] w_quot;
    logic        w_dstart;
    logic [63:0] w_dnum;

    // configuration accepted only between updates
    assign o_cfg_ready = (r_st == S_IDLE);
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign w_in_fire   = i_valid && o_ready;
    assign o_ready     = (r_st == S_IDLE) && !i_cfg_valid;
    assign w_out_load  = (r_st == S_FIN) && (!o_valid || i_ready);

    skf_mul u_mul (.i_clk, .i_rst_n, .i_req(w_mreq), .o_done(w_mdone), .o_prod(w_prod));
    skf_div #(.FRAC_BITS(FRAC_BITS)) u_div (.i_clk, .i_rst_n, .i_start(w_dstart),
        .i_num(w_dnum), .i_den(r_d), .o_done(w_ddone), .o_quot(w_quot));

    // multiplier and divider requests
    always_comb begin
        w_mreq = '0;
        w_dstart = 1'b0;
        w_dnum = r_na;
        case (r_st)
            S_DET1: if (!r_wait) begin
                w_mreq.start = 1'b1;
                w_mreq.a = 64'(r_p);
                w_mreq.b = 64'(r_ra) + 64'(r_rb);
            end
            S_DET2: if (!r_wait) begin
                w_mreq.start = 1'b1;
                w_mreq.a = 64'(r_ra);
                w_mreq.b = 64'(r_rb);
            end
            S_NUMA: if (!r_wait && !r_single) begin
                w_mreq.start = 1'b1;
                w_mreq.a = 64'(r_p);
                w_mreq.b = 64'(r_rb);
            end
            S_NUMB: if (!r_wait) begin
                w_mreq.start = 1'b1;
                w_mreq.a = 64'(r_p);
                w_mreq.b = 64'(r_ra);
            end
            S_DIVA: if (!r_wait) w_dstart = 1'b1;
            S_DIVB: if (!r_wait) begin
                w_dstart = 1'b1;
                w_dnum = r_nb;
            end
            S_CORA: if (!r_wait) begin
                w_mreq.start = 1'b1;
                w_mreq.a = 64'(r_ka);
                w_mreq.b = 64'($signed(r_za)) - 64'($signed(r_est));
            end
            S_CORB: if (!r_wait) begin
                w_mreq.start = 1'b1;
                w_mreq.a = 64'(r_kb);
                w_mreq.b = 64'($signed(r_zb)) - 64'($signed(r_est));
            end
            S_VAR: if (!r_wait) begin
                w_mreq.start = 1'b1;
                w_mreq.a = (64'(1) << FRAC_BITS) - 64'(r_ka) - 64'(r_kb);
                w_mreq.b = 64'(r_p);
            end
            default: ;
        endcase
    end

    logic [64:0] w_psum;
    logic signed [63:0] w_nx;
    logic [63:0] w_nv;
    assign w_psum = 65'(r_var) + 65'(r_q);
    assign w_nx = 64'($signed(r_est)) + ($signed(r_delta) >>> FRAC_BITS);
    assign w_nv = w_prod >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= skf_pkg::RST_PROC_NOISE;
            r_ra <= skf_pkg::RST_NOISE;
            r_rb <= skf_pkg::RST_NOISE;
            r_single <= 1'b0;
            r_est <= '0;
            r_var <= skf_pkg::RST_INIT_VAR;
            r_st <= S_IDLE;
            r_wait <= 1'b0;
            r_fault <= 1'b0;
        end else begin
            // configuration writes
            if (w_cfg_fire) begin
                case (i_cfg_index)
                    skf_pkg::CFG_PROC_NOISE: r_q <= i_cfg_data[30:0];
                    skf_pkg::CFG_NOISE_A: r_ra <= i_cfg_data[30:0];
                    skf_pkg::CFG_NOISE_B: r_rb <= i_cfg_data[30:0];
                    skf_pkg::CFG_SINGLE: r_single <= i_cfg_data[0];
                    skf_pkg::CFG_INIT_EST: r_est <= i_cfg_data;
                    skf_pkg::CFG_INIT_VAR: r_var <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // sequencer
            case (r_st)
                S_IDLE: if (w_in_fire) begin
                    r_za <= i_meas_a;
                    r_zb <= i_meas_b;
                    r_p <= w_psum[64:31] != '0 ? 31'h7FFF_FFFF : w_psum[30:0];
                    r_kb <= '0;
                    r_delta <= '0;
                    r_wait <= 1'b0;
                    r_st <= r_single ? S_NUMA : S_DET1;
                end
                S_DET1: begin
                    r_wait <= 1'b1;
                    if (w_mdone) begin
                        r_d <= w_prod;
                        r_wait <= 1'b0;
                        r_st <= S_DET2;
                    end
                end
                S_DET2: begin
                    r_wait <= 1'b1;
                    if (w_mdone) begin
                        r_d <= r_d + w_prod;
                        r_wait <= 1'b0;
                        r_st <= S_NUMA;
                        if (r_d + w_prod == '0) begin
                            r_fault <= 1'b1;
                            r_st <= S_FIN;
                        end
                    end
                end
                S_NUMA: begin
                    if (r_single) begin
                        r_d <= 64'(r_p) + 64'(r_ra);
                        r_na <= 64'(r_p);
                        r_st <= S_DIVA;
                        if (64'(r_p) + 64'(r_ra) == '0) begin
                            r_fault <= 1'b1;
                            r_st <= S_FIN;
                        end
                    end else begin
                        r_wait <= 1'b1;
                        if (w_mdone) begin
                            r_na <= w_prod;
                            r_wait <= 1'b0;
                            r_st <= S_NUMB;
                        end
                    end
                end
                S_NUMB: begin
                    r_wait <= 1'b1;
                    if (w_mdone) begin
                        r_nb <= w_prod;
                        r_wait <= 1'b0;
                        r_st <= S_DIVA;
                    end
                end
                S_DIVA: begin
                    r_wait <= 1'b1;
                    if (w_ddone) begin
                        r_ka <= w_quot;
                        r_wait <= 1'b0;
                        r_st <= r_single ? S_CORA : S_DIVB;
                    end
                end
                S_DIVB: begin
                    r_wait <= 1'b1;
                    if (w_ddone) begin
                        r_kb <= w_quot;
                        r_wait <= 1'b0;
                        r_st <= S_CORA;
                    end
                end
                S_CORA: begin
                    r_wait <= 1'b1;
                    if (w_mdone) begin
                        r_delta <= w_prod;
                        r_wait <= 1'b0;
                        r_st <= r_single ? S_VAR : S_CORB;
                    end
                end
                S_CORB: begin
                    r_wait <= 1'b1;
                    if (w_mdone) begin
                        r_delta <= r_delta + w_prod;
                        r_wait <= 1'b0;
                        r_st <= S_VAR;
                    end
                end
                S_VAR: begin
                    r_wait <= 1'b1;
                    if (w_mdone) begin
                        r_wait <= 1'b0;
                        r_fault <= 1'b0;
                        if (w_nx > 64'sh7FFF_FFFF) r_est <= 32'h7FFF_FFFF;
                        else if (w_nx < -64'sh8000_0000) r_est <= 32'h8000_0000;
                        else r_est <= w_nx[31:0];
                        r_var <= w_nv[63:31] != '0 ? 31'h7FFF_FFFF : w_nv[30:0];
                        r_st <= S_FIN;
                    end
                end
                // wait here until the output register is free
                S_FIN: if (w_out_load) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // output register, loaded when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_oest <= r_est;
            r_ovar <= r_var;
            r_ofault <= r_fault;
        end
    end

    assign o_estimate  = r_oest;
    assign o_variance  = r_ovar;
    assign o_div_fault = r_ofault;
endmodule

// ----- design/skf_checker.sv -----
module skf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_cfg_ready,
    input logic [31:0] o_estimate,
    input logic [30:0] o_variance,
    input logic        o_div_fault
);
    // a result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_estimate) && $stable(o_variance)
            && $stable(o_div_fault)) else $error("result dropped");
    // an accepted item keeps the input busy the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("input ready during update");
    // input ready only when configuration is also accepted
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> o_cfg_ready) else $error("input ready while busy");
    // reset clears the result
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result valid after reset");
endmodule

bind scalar_kalman_dual_measurement skf_checker u_chk (.i_clk, .i_rst_n, .i_valid,
    .o_ready, .o_valid, .i_ready, .o_cfg_ready, .o_estimate, .o_variance, .o_div_fault);
